@@ rtl/core/spq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

  localparam int DEPTH         = 16;
  localparam int PAYLOAD_WIDTH = 32;
  localparam int PRIO_WIDTH    = 8;
  localparam int COUNT_WIDTH   = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    FUNC_INSERT  = 2'd0,
    FUNC_EXT_MIN = 2'd1,
    FUNC_EXT_EQ  = 2'd2,
    FUNC_EXT_LE  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef struct packed {
    func_t                    func;
    logic [PRIO_WIDTH-1:0]    priority_req;
    logic [PAYLOAD_WIDTH-1:0] payload;
  } spq_in_t;

  typedef struct packed {
    status_t                  status;
    logic [PRIO_WIDTH-1:0]    out_priority;
    logic [PAYLOAD_WIDTH-1:0] out_payload;
    logic [COUNT_WIDTH-1:0]   count;
  } spq_out_t;

  typedef struct packed {
    logic                     valid;
    logic [PRIO_WIDTH-1:0]    prio;
    logic [PAYLOAD_WIDTH-1:0] payload;
  } spq_entry_t;

  typedef struct packed {
    logic                     fire;
    func_t                    func;
    logic [PRIO_WIDTH-1:0]    key;
    logic [PAYLOAD_WIDTH-1:0] payload;
    logic                     full;
    logic                     found;
  } spq_cmd_t;

  typedef struct packed {
    logic go;
    logic hit;
    logic first;
  } spq_flags_t;

endpackage

`default_nettype wire

@@ rtl/core/sorted_priority_queue_unit.sv @@
// Channel  Ports                            Moves
// -------  -------------------------------  -----------------------------------
// input    in_valid, in_ready, in_data      one command item: func, priority, payload
// output   out_valid, out_ready, out_data   one result item: status, entry, count
//
// Each command is compared in all cells at once; entries move at most one place.
// A result is registered and shows in the cycle after its command is taken.
// A new command is taken while the held result is taken, or when none is held.
// Reset (rst_n low, synchronous) empties the queue and drops any held result.
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue_unit (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire spq_pkg::spq_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output spq_pkg::spq_out_t     out_data
);

  localparam int D = spq_pkg::DEPTH;

  spq_pkg::spq_cmd_t   cmd;
  spq_pkg::spq_entry_t cell_q [D];
  spq_pkg::spq_entry_t left_q [D];
  spq_pkg::spq_entry_t right_q [D];
  spq_pkg::spq_flags_t flags [D];
  logic [D-1:0]        left_go;
  logic [D-1:0]        left_hit;
  logic [D-1:0]        first_vec;
  logic [D-1:0]        valid_vec;

  logic                                 out_valid_r;
  spq_pkg::spq_out_t                    out_data_r;
  spq_pkg::spq_out_t                    out_data_nxt;
  logic [spq_pkg::COUNT_WIDTH-1:0]      count_r;
  logic [spq_pkg::COUNT_WIDTH-1:0]      count_nxt;
  spq_pkg::spq_entry_t                  sel;

  assign in_ready = !out_valid_r || out_ready;

  always_comb begin
    cmd.fire    = in_valid && in_ready;
    cmd.func    = in_data.func;
    cmd.key     = in_data.priority_req;
    cmd.payload = in_data.payload;
    cmd.full    = valid_vec[D-1];
    cmd.found   = |first_vec;
  end

  for (genvar i = 0; i < D; i++) begin : g_cell
    if (i == 0) begin : g_head
      always_comb begin
        left_q[i]       = '0;
        left_q[i].valid = 1'b1;
        left_go[i]      = 1'b0;
        left_hit[i]     = 1'b0;
      end
    end else begin : g_body
      always_comb begin
        left_q[i]   = cell_q[i-1];
        left_go[i]  = flags[i-1].go;
        left_hit[i] = flags[i-1].hit;
      end
    end
    if (i == D - 1) begin : g_tail
      assign right_q[i] = '0;
    end else begin : g_inner
      assign right_q[i] = cell_q[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cmd),
      .left_entry  (left_q[i]),
      .right_entry (right_q[i]),
      .left_go     (left_go[i]),
      .left_hit    (left_hit[i]),
      .entry       (cell_q[i]),
      .flags       (flags[i])
    );

    assign first_vec[i] = flags[i].first;
    assign valid_vec[i] = cell_q[i].valid;
  end

  always_comb begin
    sel = '0;
    for (int i = 0; i < D; i++) begin
      if (first_vec[i]) begin
        sel = sel | cell_q[i];
      end
    end
  end

  always_comb begin
    count_nxt    = count_r;
    out_data_nxt = '0;
    if (cmd.func == spq_pkg::FUNC_INSERT) begin
      if (cmd.full) begin
        out_data_nxt.status = spq_pkg::ST_FULL;
      end else begin
        out_data_nxt.status = spq_pkg::ST_DONE;
        count_nxt           = count_r + 1'b1;
      end
    end else if (cmd.found) begin
      out_data_nxt.status       = spq_pkg::ST_DONE;
      out_data_nxt.out_priority = sel.prio;
      out_data_nxt.out_payload  = sel.payload;
      count_nxt                 = count_r - 1'b1;
    end else begin
      out_data_nxt.status = spq_pkg::ST_NOT_FOUND;
    end
    out_data_nxt.count = count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      if (cmd.fire) begin
        out_valid_r <= 1'b1;
        out_data_r  <= out_data_nxt;
        count_r     <= count_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_count_matches : assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_vec) == 32'(count_r))
    else $error("count register disagrees with valid cells");

  a_packed_prefix : assert property (@(posedge clk) disable iff (!rst_n)
    (valid_vec & (valid_vec + 1'b1)) == '0)
    else $error("valid cells do not form a packed prefix");

  a_single_match : assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(first_vec))
    else $error("more than one cell claims the match");

  a_result_follows : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fire |=> out_valid_r)
    else $error("accepted item produced no result");

  a_full_refused : assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.fire && cmd.func == spq_pkg::FUNC_INSERT && cmd.full)
      |=> (out_data_r.status == spq_pkg::ST_FULL && $stable(valid_vec)))
    else $error("insert into full queue changed state");

endmodule

`default_nettype wire

@@ rtl/core/spq_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module spq_cell (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire spq_pkg::spq_cmd_t   cmd,
  input  wire spq_pkg::spq_entry_t left_entry,
  input  wire spq_pkg::spq_entry_t right_entry,
  input  wire logic               left_go,
  input  wire logic               left_hit,
  output spq_pkg::spq_entry_t     entry,
  output spq_pkg::spq_flags_t     flags
);

  spq_pkg::spq_entry_t entry_r;
  spq_pkg::spq_entry_t entry_nxt;
  logic                ge;
  logic                le;
  logic                eq;
  logic                go;
  logic                hit;
  logic                shift;

  always_comb begin
    ge = entry_r.valid && (entry_r.prio >= cmd.key);
    le = entry_r.valid && (entry_r.prio <= cmd.key);
    eq = entry_r.valid && (entry_r.prio == cmd.key);
    go = !entry_r.valid || (cmd.key <= entry_r.prio);
    case (cmd.func)
      spq_pkg::FUNC_EXT_MIN: hit = entry_r.valid;
      spq_pkg::FUNC_EXT_EQ:  hit = eq;
      spq_pkg::FUNC_EXT_LE:  hit = le;
      default:               hit = 1'b0;
    endcase
    shift = cmd.found && ((cmd.func != spq_pkg::FUNC_EXT_EQ) || ge);
  end

  always_comb begin
    entry_nxt = entry_r;
    if (cmd.fire) begin
      if (cmd.func == spq_pkg::FUNC_INSERT) begin
        if (!cmd.full) begin
          entry_nxt.valid = entry_r.valid || left_entry.valid;
          if (go) begin
            if (left_go) begin
              entry_nxt.prio    = left_entry.prio;
              entry_nxt.payload = left_entry.payload;
            end else begin
              entry_nxt.prio    = cmd.key;
              entry_nxt.payload = cmd.payload;
            end
          end
        end
      end else if (shift) begin
        entry_nxt = right_entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r.valid <= 1'b0;
    end else begin
      entry_r <= entry_nxt;
    end
  end

  assign entry       = entry_r;
  assign flags.go    = go;
  assign flags.hit   = hit;
  assign flags.first = hit && !left_hit;

endmodule

`default_nettype wire

@@ tb/sv/tb_sorted_priority_queue_unit.sv @@
`timescale 1ns / 1ps

module tb_sorted_priority_queue_unit;

  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 20;
  localparam int SEGMENT_LEN = 20;
  localparam int PHASE_ITEMS = 275;

  typedef struct {
    spq_pkg::spq_in_t cmd;
    int               idle_pct;
    int               stall_pct;
    bit               wait_empty;
  } pending_cmd_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  spq_pkg::spq_in_t  in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  spq_pkg::spq_out_t out_data;

  pending_cmd_t      cmd_backlog[$];
  spq_pkg::spq_out_t expected_results[$];
  int                recv_stall_pct = 0;
  int                results_owed = 0;
  int                mismatch_count = 0;
  int                cycle_count = 0;

  logic [spq_pkg::PRIO_WIDTH-1:0]    shadow_prio[spq_pkg::DEPTH];
  logic [spq_pkg::PAYLOAD_WIDTH-1:0] shadow_payload[spq_pkg::DEPTH];
  int                                shadow_count = 0;

  sorted_priority_queue_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  function automatic spq_pkg::spq_out_t predict_queue_op(spq_pkg::spq_in_t cmd);
    spq_pkg::spq_out_t res;
    int pos;
    bit hit;
    res = '0;
    res.status = spq_pkg::ST_NOT_FOUND;
    if (cmd.func == spq_pkg::FUNC_INSERT) begin
      if (shadow_count >= spq_pkg::DEPTH) begin
        res.status = spq_pkg::ST_FULL;
      end else begin
        pos = 0;
        while (pos < shadow_count && cmd.priority_req > shadow_prio[pos]) pos++;
        for (int i = shadow_count; i > pos; i--) begin
          shadow_prio[i] = shadow_prio[i-1];
          shadow_payload[i] = shadow_payload[i-1];
        end
        shadow_prio[pos] = cmd.priority_req;
        shadow_payload[pos] = cmd.payload;
        shadow_count++;
        res.status = spq_pkg::ST_DONE;
      end
    end else begin
      pos = shadow_count;
      for (int i = 0; i < shadow_count; i++) begin
        case (cmd.func)
          spq_pkg::FUNC_EXT_MIN: hit = 1'b1;
          spq_pkg::FUNC_EXT_EQ:  hit = (shadow_prio[i] == cmd.priority_req);
          default:               hit = (shadow_prio[i] <= cmd.priority_req);
        endcase
        if (hit) begin
          pos = i;
          break;
        end
      end
      if (pos < shadow_count) begin
        res.out_priority = shadow_prio[pos];
        res.out_payload = shadow_payload[pos];
        for (int i = pos; i + 1 < shadow_count; i++) begin
          shadow_prio[i] = shadow_prio[i+1];
          shadow_payload[i] = shadow_payload[i+1];
        end
        shadow_count--;
        res.status = spq_pkg::ST_DONE;
      end
    end
    res.count = shadow_count[spq_pkg::COUNT_WIDTH-1:0];
    return res;
  endfunction

  task automatic log_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  task automatic queue_cmd(spq_pkg::func_t f, logic [spq_pkg::PRIO_WIDTH-1:0] prio,
                           logic [spq_pkg::PAYLOAD_WIDTH-1:0] data, int idle_pct,
                           int stall_pct, bit wait_empty = 1'b0);
    pending_cmd_t item;
    item.cmd.func = f;
    item.cmd.priority_req = prio;
    item.cmd.payload = data;
    item.idle_pct = idle_pct;
    item.stall_pct = stall_pct;
    item.wait_empty = wait_empty;
    cmd_backlog.push_back(item);
  endtask

  function automatic logic [spq_pkg::PRIO_WIDTH-1:0] pick_prio();
    int sel;
    sel = $urandom_range(9);
    if (sel < 4) return spq_pkg::PRIO_WIDTH'($urandom_range(15));
    if (sel == 4) return '0;
    if (sel == 5) return '1;
    return spq_pkg::PRIO_WIDTH'($urandom_range(255));
  endfunction

  // Driver: hold the item until taken, then advance from the backlog.
  always @(posedge clk) begin : driver
    pending_cmd_t nxt;
    int owed_after;
    if (rst_n && (!in_valid || in_ready)) begin
      owed_after = results_owed + int'(in_valid && in_ready) - int'(out_valid && out_ready);
      if (cmd_backlog.size() > 0 && !(cmd_backlog[0].wait_empty && owed_after > 0) &&
          $urandom_range(99) >= cmd_backlog[0].idle_pct) begin
        nxt = cmd_backlog.pop_front();
        in_valid <= 1'b1;
        in_data <= nxt.cmd;
        recv_stall_pct <= nxt.stall_pct;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor: check the oldest expectation first, then predict the newly taken item.
  always @(posedge clk) begin : monitor
    spq_pkg::spq_out_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          log_mismatch($sformatf("unexpected result status=%0d prio=%0d payload=%h count=%0d",
                                 out_data.status, out_data.out_priority,
                                 out_data.out_payload, out_data.count));
        end else begin
          want = expected_results.pop_front();
          if (out_data.status !== want.status ||
              out_data.out_priority !== want.out_priority ||
              out_data.out_payload !== want.out_payload ||
              out_data.count !== want.count)
            log_mismatch($sformatf(
              "exp status=%0d prio=%0d payload=%h count=%0d, got %0d %0d %h %0d",
              want.status, want.out_priority, want.out_payload, want.count,
              out_data.status, out_data.out_priority, out_data.out_payload, out_data.count));
        end
      end
      if (in_valid && in_ready) expected_results.push_back(predict_queue_op(in_data));
      results_owed <= results_owed + int'(in_valid && in_ready) - int'(out_valid && out_ready);
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int idle_tab[4];
    int stall_tab[4];
    int made;
    int seg;
    int insert_pct;
    spq_pkg::func_t f;
    idle_tab = '{0, 58, 0, 36};
    stall_tab = '{0, 0, 58, 36};

    queue_cmd(spq_pkg::FUNC_EXT_MIN, 8'd0, 32'h0, 0, 0);
    queue_cmd(spq_pkg::FUNC_EXT_EQ, 8'd0, 32'hFFFF_FFFF, 0, 0);
    queue_cmd(spq_pkg::FUNC_EXT_LE, 8'd255, 32'h0, 0, 0);
    queue_cmd(spq_pkg::FUNC_INSERT, 8'd255, 32'hFFFF_FFFF, 0, 0);
    queue_cmd(spq_pkg::FUNC_INSERT, 8'd0, 32'h0, 0, 0);
    queue_cmd(spq_pkg::FUNC_INSERT, 8'd5, 32'hAAAA_5555, 0, 0);
    queue_cmd(spq_pkg::FUNC_INSERT, 8'd5, 32'h5555_AAAA, 0, 0);
    queue_cmd(spq_pkg::FUNC_EXT_EQ, 8'd5, 32'h1234_5678, 0, 0);
    queue_cmd(spq_pkg::FUNC_EXT_EQ, 8'd7, 32'h0, 0, 0);
    queue_cmd(spq_pkg::FUNC_EXT_LE, 8'd4, 32'h0, 0, 0);
    queue_cmd(spq_pkg::FUNC_EXT_LE, 8'd4, 32'h0, 0, 0);
    queue_cmd(spq_pkg::FUNC_EXT_EQ, 8'd255, 32'h0, 0, 0);
    queue_cmd(spq_pkg::FUNC_EXT_LE, 8'd255, 32'h0, 0, 0);
    queue_cmd(spq_pkg::FUNC_INSERT, 8'd128, 32'h8000_0001, 0, 0);
    queue_cmd(spq_pkg::FUNC_EXT_MIN, 8'd200, 32'h0, 0, 0);
    queue_cmd(spq_pkg::FUNC_EXT_MIN, 8'd0, 32'h0, 0, 0);

    for (int ph = 0; ph < 4; ph++) begin
      made = 0;
      seg = 0;
      while (made < PHASE_ITEMS) begin
        // Start with an insert-heavy fill burst, then mix bursts.
        case ((seg == 0) ? 0 : $urandom_range(2))
          0: insert_pct = 85;
          1: insert_pct = 15;
          default: insert_pct = 50;
        endcase
        for (int k = 0; k < SEGMENT_LEN; k++) begin
          if ($urandom_range(99) < insert_pct) f = spq_pkg::FUNC_INSERT;
          else f = spq_pkg::func_t'($urandom_range(1, 3));
          queue_cmd(f, pick_prio(), $urandom(), idle_tab[ph], stall_tab[ph],
                    (k == 0 && seg == 0));
          made++;
        end
        seg++;
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    while (cmd_backlog.size() != 0 || in_valid || results_owed > 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (expected_results.size() != 0)
      log_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ sorted_priority_queue_unit.f @@
rtl/core/spq_pkg.sv
rtl/core/spq_cell.sv
rtl/core/sorted_priority_queue_unit.sv
tb/sv/tb_sorted_priority_queue_unit.sv
